FILE: rtl/ellipsoid_point_projection_defines.svh
// Assertion macros for the ellipsoid projection block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ELLIPSOID_POINT_PROJECTION_DEFINES_SVH
`define ELLIPSOID_POINT_PROJECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define EPP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ellipsoid projection check failed");
// next-cycle implication
`define EPP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ellipsoid projection check failed");
`else
`define EPP_ASSERT_IMP(name, ante, cons)
`define EPP_ASSERT_NXT(name, ante, cons)
`endif
`endif

FILE: rtl/epp_pkg.sv
// Shared types, constants and saturating helpers for the ellipsoid projection.
// No dependencies; used by epp_arith and ellipsoid_point_projection.
package epp_pkg;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

    localparam logic [1:0] CFG_RADIUS_X  = 2'd0;
    localparam logic [1:0] CFG_RADIUS_Y  = 2'd1;
    localparam logic [1:0] CFG_RADIUS_Z  = 2'd2;
    localparam logic [1:0] CFG_STEP_TOL  = 2'd3;

    typedef enum logic [2:0] {
        OP_FMUL,
        OP_FMULDIV,
        OP_FDIV,
        OP_PROD,
        OP_ISQRT
    } arith_op_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DPREP,
        A_DIV,
        A_SQRT,
        A_DONE
    } arith_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AA,
        S_WA,
        S_SQ,
        S_INS,
        S_ROOT,
        S_HMIN,
        S_HM,
        S_HSTART,
        S_PI,
        S_PXX,
        S_DQ,
        S_DH,
        S_FIN,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic               start;
        arith_op_t          op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic [127:0]       x;
    } arith_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] res;
        logic [127:0]       prod;
    } arith_rsp_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // magnitude plus sign back to a saturated signed 64-bit value
    function automatic logic signed [63:0] from_mag(input logic neg, input logic [127:0] m);
        if (m[127:64] != 64'd0)
            return neg ? S64_MIN : S64_MAX;
        if (neg)
            return m[63] ? S64_MIN : (64'd0 - m[63:0]);
        return m[63] ? S64_MAX : m[63:0];
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
        return (a == S64_MIN) ? S64_MAX : (64'sd0 - a);
    endfunction

    function automatic logic signed [63:0] avg_floor(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        return s[64:1];
    endfunction

    function automatic logic signed [31:0] out32(input logic signed [63:0] v);
        if (v > S32_MAX)
            return 32'sh7FFF_FFFF;
        if (v < S32_MIN)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

FILE: rtl/epp_arith.sv
// Shared multi-cycle arithmetic unit: 32x32 partial-product multiplier,
// bit-serial 128/64 divider and bit-pair integer square root. Uses epp_pkg.
module epp_arith
    import epp_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    arith_state_t       state_reg, state_next;
    arith_op_t          op_reg, op_next;
    logic               neg_reg, neg_next;
    logic [63:0]        ma_reg, ma_next;
    logic [63:0]        mb_reg, mb_next;
    logic [63:0]        md_reg, md_next;
    logic [127:0]       acc_reg, acc_next;
    logic [1:0]         mcnt_reg, mcnt_next;
    logic [127:0]       num_reg, num_next;
    logic [127:0]       quo_reg, quo_next;
    logic [63:0]        rem_reg, rem_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [65:0]        sqr_reg, sqr_next;
    logic [63:0]        root_reg, root_next;
    logic signed [63:0] res_reg, res_next;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [6:0]   sh;
    logic [127:0] acc_sum;
    logic [64:0]  r65;
    logic         ge_d;
    logic [66:0]  r67, trial;
    logic         ge_s;
    logic [127:0] quo_step;
    logic [63:0]  root_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        md_reg   <= md_next;
        acc_reg  <= acc_next;
        mcnt_reg <= mcnt_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        sqr_reg  <= sqr_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        // datapath for each step kind
        pa      = mcnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb      = mcnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp      = pa * pb;
        sh      = {mcnt_reg[0] & mcnt_reg[1], mcnt_reg[0] ^ mcnt_reg[1], 5'd0};
        acc_sum = acc_reg + ({64'd0, pp} << sh);

        r65      = {rem_reg, num_reg[127]};
        ge_d     = r65 >= {1'b0, md_reg};
        quo_step = {quo_reg[126:0], ge_d};

        r67       = {sqr_reg[64:0], num_reg[127:126]};
        trial     = {1'b0, root_reg, 2'b01};
        ge_s      = r67 >= trial;
        root_step = {root_reg[62:0], ge_s};

        state_next = state_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        md_next    = md_reg;
        acc_next   = acc_reg;
        mcnt_next  = mcnt_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sqr_next   = sqr_reg;
        root_next  = root_reg;
        res_next   = res_reg;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    ma_next   = mag64(req.a);
                    mb_next   = mag64(req.b);
                    md_next   = mag64(req.c);
                    acc_next  = 128'd0;
                    mcnt_next = 2'd0;
                    neg_next  = req.a[63] ^ req.b[63];
                    case (req.op)
                        OP_FMUL, OP_PROD:
                        begin
                            state_next = A_MUL;
                        end
                        OP_FMULDIV:
                        begin
                            neg_next   = req.a[63] ^ req.b[63] ^ req.c[63];
                            state_next = A_MUL;
                        end
                        OP_FDIV:
                        begin
                            md_next    = mag64(req.b);
                            num_next   = {64'd0, mag64(req.a)} << FRAC_BITS;
                            state_next = A_DPREP;
                        end
                        OP_ISQRT:
                        begin
                            num_next   = req.x;
                            sqr_next   = 66'd0;
                            root_next  = 64'd0;
                            cnt_next   = 7'd63;
                            state_next = A_SQRT;
                        end
                        default:
                        begin
                            state_next = A_IDLE;
                        end
                    endcase
                end
            end

            A_MUL:
            begin
                acc_next  = acc_sum;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    case (op_reg)
                        OP_FMUL:
                        begin
                            res_next   = from_mag(neg_reg, acc_sum >> FRAC_BITS);
                            state_next = A_DONE;
                        end
                        OP_FMULDIV:
                        begin
                            num_next   = acc_sum;
                            state_next = A_DPREP;
                        end
                        default:
                        begin
                            state_next = A_DONE;
                        end
                    endcase
                end
            end

            A_DPREP:
            begin
                if (md_reg == 64'd0)
                begin
                    // divide by zero: zero stays zero, else saturate toward the sign
                    if (num_reg == 128'd0)
                        res_next = 64'sd0;
                    else
                        res_next = neg_reg ? S64_MIN : S64_MAX;
                    state_next = A_DONE;
                end
                else
                begin
                    rem_next   = 64'd0;
                    quo_next   = 128'd0;
                    cnt_next   = 7'd127;
                    state_next = A_DIV;
                end
            end

            A_DIV:
            begin
                rem_next = ge_d ? 64'(r65 - {1'b0, md_reg}) : r65[63:0];
                quo_next = quo_step;
                num_next = {num_reg[126:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    res_next   = from_mag(neg_reg, quo_step);
                    state_next = A_DONE;
                end
            end

            A_SQRT:
            begin
                sqr_next  = ge_s ? 66'(r67 - trial) : r67[65:0];
                root_next = root_step;
                num_next  = {num_reg[125:0], 2'b00};
                cnt_next  = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    res_next   = root_step[63] ? S64_MAX : root_step;
                    state_next = A_DONE;
                end
            end

            A_DONE:
            begin
                state_next = A_IDLE;
            end

            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    assign rsp.busy = (state_reg != A_IDLE);
    assign rsp.done = (state_reg == A_DONE);
    assign rsp.res  = res_reg;
    assign rsp.prod = acc_reg;

endmodule

FILE: rtl/ellipsoid_point_projection.sv
// Top level: config registers, request handshakes and the Newton sequencer.
// Depends on epp_pkg, epp_arith and ellipsoid_point_projection_defines.svh.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  point    | in        | point_valid / point_ready | point_x, point_y, point_z
//  proj     | out       | proj_valid / proj_ready   | proj_x, proj_y, proj_z
//  cfg      | in        | cfg_we (no wait)          | cfg_index, cfg_data
//
// One request at a time; point_ready is low from acceptance until the result is taken.
// All arithmetic goes through one shared unit. Points with two zero coordinates skip
// the iteration and go straight to the output. Otherwise a setup over the n axes
// (n = 2 or 3; a point inside adds one divide) precedes up to 2*MAX_NEWTON_STEPS
// Newton passes, then one muldiv per axis for the outputs.
// No clearing pass after reset.
`include "ellipsoid_point_projection_defines.svh"

module ellipsoid_point_projection
    import epp_pkg::*;
#(
    parameter int MAX_NEWTON_STEPS = 21,
    parameter int FRAC_BITS        = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               proj_valid,
    input  logic               proj_ready,
    output logic signed [31:0] proj_x,
    output logic signed [31:0] proj_y,
    output logic signed [31:0] proj_z,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    localparam int PASS_CAP = 2 * MAX_NEWTON_STEPS;
    localparam int CNT_W    = $clog2(MAX_NEWTON_STEPS + 1);
    localparam int PASS_W   = $clog2(PASS_CAP + 1);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic [30:0] radius_x_reg, radius_y_reg, radius_z_reg;
    logic [24:0] tol_reg;

    seq_state_t         state_reg, state_next;
    logic               issued_reg, issued_next;
    logic [1:0]         k_reg, k_next;
    logic [1:0]         klast_reg, klast_next;
    logic [1:0]         map_reg [3];
    logic [1:0]         map_next [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] w_next [3];
    logic [30:0]        r_reg [3];
    logic [30:0]        r_next [3];
    logic signed [63:0] aa_reg [3];
    logic signed [63:0] aa_next [3];
    logic signed [31:0] pout_reg [3];
    logic signed [31:0] pout_next [3];
    logic signed [63:0] big_reg, big_next;
    logic signed [63:0] small_reg, small_next;
    logic [30:0]        rmax_reg, rmax_next;
    logic [30:0]        rmin_reg, rmin_next;
    logic [127:0]       s_reg, s_next;
    logic signed [63:0] ins_reg, ins_next;
    logic signed [63:0] root_reg, root_next;
    logic signed [63:0] hmin_reg, hmin_next;
    logic signed [63:0] h_reg, h_next;
    logic signed [63:0] tmp_reg, tmp_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [63:0] dsum_reg, dsum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PASS_W-1:0]  passes_reg, passes_next;

    arith_req_t arith_req;
    arith_rsp_t arith_rsp;

    logic signed [63:0] ures;
    logic signed [63:0] cur_w, cur_r, cur_aa, cur_aah, aw;
    logic signed [31:0] pw [3];
    logic [30:0]        prad [3];
    logic [1:0]         ia, ib;
    logic               zx, zy, zz, three, last_k, op_state, done;
    logic signed [63:0] aa_c, hm_c, hz_c, t_c, dh_c, hn_c;
    logic [CNT_W-1:0]   cnt_c;
    logic [PASS_W-1:0]  pass_c;
    logic               stop_c;

    epp_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg <= 31'd16777216;
            radius_y_reg <= 31'd16777216;
            radius_z_reg <= 31'd16777216;
            tol_reg      <= 25'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS_X: radius_x_reg <= cfg_data;
                CFG_RADIUS_Y: radius_y_reg <= cfg_data;
                CFG_RADIUS_Z: radius_z_reg <= cfg_data;
                CFG_STEP_TOL: tol_reg      <= cfg_data[24:0];
                default:      tol_reg      <= tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            cnt_reg    <= '0;
            passes_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            cnt_reg    <= cnt_next;
            passes_reg <= passes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        klast_reg <= klast_next;
        map_reg   <= map_next;
        w_reg     <= w_next;
        r_reg     <= r_next;
        aa_reg    <= aa_next;
        pout_reg  <= pout_next;
        big_reg   <= big_next;
        small_reg <= small_next;
        rmax_reg  <= rmax_next;
        rmin_reg  <= rmin_next;
        s_reg     <= s_next;
        ins_reg   <= ins_next;
        root_reg  <= root_next;
        hmin_reg  <= hmin_next;
        h_reg     <= h_next;
        tmp_reg   <= tmp_next;
        sum_reg   <= sum_next;
        dsum_reg  <= dsum_next;
    end

    assign ures    = arith_rsp.res;
    assign cur_w   = {{32{w_reg[k_reg][31]}}, w_reg[k_reg]};
    assign cur_r   = {33'd0, r_reg[k_reg]};
    assign cur_aa  = aa_reg[k_reg];
    assign cur_aah = sadd(cur_aa, h_reg);
    assign aw      = cur_w[63] ? (64'sd0 - cur_w) : cur_w;
    assign last_k  = (k_reg == klast_reg);

    assign pw[0]   = point_x;
    assign pw[1]   = point_y;
    assign pw[2]   = point_z;
    assign prad[0] = radius_x_reg;
    assign prad[1] = radius_y_reg;
    assign prad[2] = radius_z_reg;
    assign zx      = (point_x == 32'sd0);
    assign zy      = (point_y == 32'sd0);
    assign zz      = (point_z == 32'sd0);
    assign three   = !zx && !zy && !zz;

    always_comb
    begin
        if (zx)
        begin
            ia = 2'd1;
            ib = 2'd2;
        end
        else if (zy)
        begin
            ia = 2'd0;
            ib = 2'd2;
        end
        else
        begin
            ia = 2'd0;
            ib = 2'd1;
        end
    end

    // request to the shared unit
    always_comb
    begin
        op_state = 1'b1;
        arith_req.op = OP_FMUL;
        arith_req.a  = cur_r;
        arith_req.b  = cur_r;
        arith_req.c  = cur_aa;
        arith_req.x  = s_reg;
        case (state_reg)
            S_AA:
            begin
                arith_req.op = OP_FMUL;
            end
            S_WA:
            begin
                arith_req.op = OP_FMUL;
                arith_req.a  = cur_w;
                arith_req.b  = cur_aa;
            end
            S_SQ:
            begin
                arith_req.op = OP_PROD;
                arith_req.a  = tmp_reg;
                arith_req.b  = tmp_reg;
            end
            S_INS:
            begin
                arith_req.op = OP_FMULDIV;
                arith_req.a  = cur_w;
                arith_req.b  = cur_w;
            end
            S_ROOT:
            begin
                arith_req.op = OP_ISQRT;
            end
            S_HMIN:
            begin
                arith_req.op = OP_FDIV;
                arith_req.a  = root_reg;
                arith_req.b  = {33'd0, rmax_reg};
            end
            S_HM:
            begin
                arith_req.op = OP_FMUL;
                arith_req.a  = aw - cur_r;
            end
            S_HSTART:
            begin
                arith_req.op = OP_FDIV;
                arith_req.a  = root_reg;
                arith_req.b  = {33'd0, rmin_reg};
            end
            S_PI, S_FIN:
            begin
                arith_req.op = OP_FMULDIV;
                arith_req.a  = cur_w;
                arith_req.b  = cur_aa;
                arith_req.c  = cur_aah;
            end
            S_PXX:
            begin
                arith_req.op = OP_FMULDIV;
                arith_req.a  = tmp_reg;
                arith_req.b  = tmp_reg;
            end
            S_DQ:
            begin
                arith_req.op = OP_FDIV;
                arith_req.a  = tmp_reg;
                arith_req.b  = cur_aah;
            end
            S_DH:
            begin
                arith_req.op = OP_FDIV;
                arith_req.a  = ONE - sum_reg;
                arith_req.b  = sadd(dsum_reg, dsum_reg);
            end
            default:
            begin
                op_state = 1'b0;
            end
        endcase
        arith_req.start = op_state && !issued_reg;
    end

    assign done = issued_reg && arith_rsp.done;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        k_next      = k_reg;
        klast_next  = klast_reg;
        map_next    = map_reg;
        w_next      = w_reg;
        r_next      = r_reg;
        aa_next     = aa_reg;
        pout_next   = pout_reg;
        big_next    = big_reg;
        small_next  = small_reg;
        rmax_next   = rmax_reg;
        rmin_next   = rmin_reg;
        s_next      = s_reg;
        ins_next    = ins_reg;
        root_next   = root_reg;
        hmin_next   = hmin_reg;
        h_next      = h_reg;
        tmp_next    = tmp_reg;
        sum_next    = sum_reg;
        dsum_next   = dsum_reg;
        cnt_next    = cnt_reg;
        passes_next = passes_reg;

        aa_c   = (ures < 64'sd1) ? 64'sd1 : ures;
        hm_c   = (ures > hmin_reg) ? ures : hmin_reg;
        hz_c   = (hm_c < 64'sd0) ? 64'sd0 : hm_c;
        t_c    = ures - small_reg;
        dh_c   = sneg(ures);
        hn_c   = sadd(h_reg, dh_c);
        cnt_c  = cnt_reg + CNT_W'(1);
        pass_c = passes_reg + PASS_W'(1);
        stop_c = mag64(dh_c) <= {39'd0, tol_reg};
        if (hn_c < hmin_reg)
            stop_c = stop_c || (pass_c >= PASS_W'(PASS_CAP));
        else
            stop_c = stop_c || (cnt_c >= CNT_W'(MAX_NEWTON_STEPS))
                     || (pass_c >= PASS_W'(PASS_CAP));

        if (op_state)
        begin
            if (!issued_reg)
                issued_next = 1'b1;
            else if (arith_rsp.done)
                issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    pout_next[0] = 32'sd0;
                    pout_next[1] = 32'sd0;
                    pout_next[2] = 32'sd0;
                    if (!three && pw[ia] == 32'sd0)
                    begin
                        // other coordinate of the pair gives +/- radius, zero as negative
                        pout_next[ib] = (pw[ib] > 32'sd0) ? {1'b0, prad[ib]}
                                                          : (32'sd0 - {1'b0, prad[ib]});
                        state_next = S_OUT;
                    end
                    else if (!three && pw[ib] == 32'sd0)
                    begin
                        pout_next[ia] = (pw[ia] > 32'sd0) ? {1'b0, prad[ia]}
                                                          : (32'sd0 - {1'b0, prad[ia]});
                        state_next = S_OUT;
                    end
                    else
                    begin
                        map_next[0] = three ? 2'd0 : ia;
                        map_next[1] = three ? 2'd1 : ib;
                        map_next[2] = 2'd2;
                        klast_next  = three ? 2'd2 : 2'd1;
                        for (int i = 0; i < 3; i++)
                        begin
                            w_next[i] = pw[map_next[i]];
                            r_next[i] = prad[map_next[i]];
                        end
                        big_next    = 64'sd0;
                        small_next  = S64_MAX;
                        rmax_next   = 31'd0;
                        rmin_next   = 31'h7FFF_FFFF;
                        s_next      = 128'd0;
                        ins_next    = 64'sd0;
                        cnt_next    = '0;
                        passes_next = '0;
                        k_next      = 2'd0;
                        state_next  = S_AA;
                    end
                end
            end

            S_AA:
            begin
                if (done)
                begin
                    aa_next[k_reg] = aa_c;
                    if (aa_c > big_reg)
                        big_next = aa_c;
                    if (aa_c < small_reg)
                        small_next = aa_c;
                    if (r_reg[k_reg] > rmax_reg)
                        rmax_next = r_reg[k_reg];
                    if (r_reg[k_reg] < rmin_reg)
                        rmin_next = r_reg[k_reg];
                    state_next = S_WA;
                end
            end

            S_WA:
            begin
                if (done)
                begin
                    tmp_next   = ures;
                    state_next = S_SQ;
                end
            end

            S_SQ:
            begin
                if (done)
                begin
                    s_next     = s_reg + arith_rsp.prod;
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                if (done)
                begin
                    ins_next = sadd(ins_reg, ures);
                    if (last_k)
                    begin
                        k_next     = 2'd0;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_AA;
                    end
                end
            end

            S_ROOT:
            begin
                if (done)
                begin
                    root_next  = ures;
                    state_next = S_HMIN;
                end
            end

            S_HMIN:
            begin
                if (done)
                begin
                    hmin_next  = ures - big_reg;
                    k_next     = 2'd0;
                    state_next = S_HM;
                end
            end

            S_HM:
            begin
                if (done)
                begin
                    hmin_next = hm_c;
                    if (!last_k)
                    begin
                        k_next = k_reg + 2'd1;
                    end
                    else if (ins_reg > ONE)
                    begin
                        // point outside: start at the clamped lower bound
                        hmin_next  = hz_c;
                        h_next     = hz_c;
                        k_next     = 2'd0;
                        sum_next   = 64'sd0;
                        dsum_next  = 64'sd0;
                        state_next = S_PI;
                    end
                    else
                    begin
                        state_next = S_HSTART;
                    end
                end
            end

            S_HSTART:
            begin
                if (done)
                begin
                    h_next     = (t_c < 64'sd0) ? t_c : 64'sd0;
                    k_next     = 2'd0;
                    sum_next   = 64'sd0;
                    dsum_next  = 64'sd0;
                    state_next = S_PI;
                end
            end

            S_PI:
            begin
                if (done)
                begin
                    tmp_next   = ures;
                    state_next = S_PXX;
                end
            end

            S_PXX:
            begin
                if (done)
                begin
                    tmp_next   = ures;
                    sum_next   = sadd(sum_reg, ures);
                    state_next = S_DQ;
                end
            end

            S_DQ:
            begin
                if (done)
                begin
                    dsum_next = sadd(dsum_reg, ures);
                    if (last_k)
                    begin
                        k_next     = 2'd0;
                        state_next = S_DH;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_PI;
                    end
                end
            end

            S_DH:
            begin
                if (done)
                begin
                    passes_next = pass_c;
                    if (hn_c < hmin_reg)
                    begin
                        // overshoot below the bound: halve toward it
                        h_next = avg_floor(h_reg, hmin_reg);
                    end
                    else
                    begin
                        h_next   = hn_c;
                        cnt_next = cnt_c;
                    end
                    k_next     = 2'd0;
                    sum_next   = 64'sd0;
                    dsum_next  = 64'sd0;
                    state_next = stop_c ? S_FIN : S_PI;
                end
            end

            S_FIN:
            begin
                if (done)
                begin
                    pout_next[map_reg[k_reg]] = out32(ures);
                    if (last_k)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            S_OUT:
            begin
                if (proj_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign point_ready = (state_reg == S_IDLE);
    assign proj_valid  = (state_reg == S_OUT);
    assign proj_x      = pout_reg[0];
    assign proj_y      = pout_reg[1];
    assign proj_z      = pout_reg[2];

    `EPP_ASSERT_IMP(a_one_at_a_time, proj_valid, !point_ready)
    `EPP_ASSERT_IMP(a_start_when_free, arith_req.start, !arith_rsp.busy)
    `EPP_ASSERT_IMP(a_pass_bound, 1'b1, passes_reg <= PASS_W'(PASS_CAP))
    `EPP_ASSERT_NXT(a_back_to_idle, proj_valid && proj_ready, point_ready)

endmodule
